// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define LPHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPHT_ASSERT(lbl, prop, msg)
`define LPHT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== sv/lpht_pkg.sv =====
package lpht_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_W     = $clog2(SLOT_COUNT);
  localparam int ENTRY_W   = 1 + KEY_BITS + VALUE_BITS;
  localparam int HASH_BITS = 32;
  localparam bit SLOT_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

  // hash reduction: bits folded into the remainder per cycle
  localparam int MOD_STEP   = 4;
  localparam int MOD_CYCLES = HASH_BITS / MOD_STEP;
  localparam int MCNT_W     = $clog2(MOD_CYCLES);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_FIND   = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;

endpackage

// ===== sv/lpht_ram.sv =====
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/linear_probe_hash_table.sv =====
// Open-addressing hash table with linear probing, one request per item.
// Input channel (in_valid / in_stall): request type (insert, remove, find),
// key, externally computed hash and the value to store on insert.
// Output channel (out_valid / out_stall): status (ok, not_found, table_full)
// and the value found or removed, zero otherwise. Exactly one result per item.
// Items are handled one at a time. Slots live in a single RAM with a
// registered read port, which reads one slot per cycle during the probe.
// With a power-of-two slot count the low hash bits name the first slot
// probed; otherwise the hash is reduced modulo the slot count first, four
// bits per cycle. A probe reads from one slot up to every slot, and the
// next item is accepted only once the result has been handed to the output
// register. An unused request code skips the probe and goes straight to
// the output state.
// After reset the valid marks are cleared by a pass over the RAM, one slot
// per cycle; in_stall stays high meanwhile.
// A finished result sits in the output register; the next item is accepted
// while it waits. If out_stall holds it, the following result waits inside
// the block and in_stall stays high until the output register frees up.
`include "assert_macros.svh"

module linear_probe_hash_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_key,
  input  logic [31:0] in_hash_value,
  input  logic [31:0] in_value_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_value_out
);

  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_CHECK,
    S_OUT
  } state_t;

  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
  localparam logic [IDX_W:0]    SLOTS_EXT = (IDX_W + 1)'(SLOT_COUNT);
  localparam logic [MCNT_W-1:0] LAST_MOD  = MCNT_W'(MOD_CYCLES - 1);

  state_t                 state_r, state_nxt;
  logic [IDX_W-1:0]       clr_r, clr_nxt;
  logic [1:0]             req_r, req_nxt;
  logic [KEY_BITS-1:0]    key_r, key_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [HASH_BITS-1:0]   hash_r, hash_nxt;
  logic [IDX_W-1:0]       rem_r, rem_nxt;
  logic [MCNT_W-1:0]      mcnt_r, mcnt_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [1:0]             res_status_r, res_status_nxt;
  logic [31:0]            res_value_r, res_value_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             out_status_r, out_status_nxt;
  logic [31:0]            out_value_r, out_value_nxt;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]     ram_rdata;

  logic                   rd_valid;
  logic [KEY_BITS-1:0]    rd_key;
  logic [VALUE_BITS-1:0]  rd_value;
  logic                   hit;
  logic [IDX_W-1:0]       idx_inc;
  logic [IDX_W-1:0]       mod_rem;
  logic [IDX_W:0]         mod_t;

  lpht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_valid = ram_rdata[ENTRY_W-1];
  assign rd_key   = ram_rdata[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rd_value = ram_rdata[VALUE_BITS-1:0];
  assign hit      = !rd_valid || (rd_key == key_r);
  assign idx_inc  = (idx_r == LAST_SLOT) ? '0 : idx_r + 1'b1;

  // restoring reduction of the hash, msb first
  always_comb begin
    mod_rem = rem_r;
    mod_t   = '0;
    for (int i = 0; i < MOD_STEP; i++) begin
      mod_t = {mod_rem, hash_r[HASH_BITS-1-i]};
      if (mod_t >= SLOTS_EXT) begin
        mod_t = mod_t - SLOTS_EXT;
      end
      mod_rem = mod_t[IDX_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    req_nxt        = req_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hash_nxt       = hash_r;
    rem_nxt        = rem_r;
    mcnt_nxt       = mcnt_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_raddr      = idx_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_req_type;
          key_nxt  = KEY_BITS'(in_key);
          val_nxt  = VALUE_BITS'(in_value_in);
          hash_nxt = in_hash_value;
          rem_nxt  = '0;
          mcnt_nxt = '0;
          cnt_nxt  = '0;
          if (in_req_type != REQ_INSERT && in_req_type != REQ_REMOVE &&
              in_req_type != REQ_FIND) begin
            // unused request code: no probe, no change
            res_status_nxt = ST_NOT_FOUND;
            res_value_nxt  = '0;
            state_nxt      = S_OUT;
          end else if (SLOT_POW2) begin
            idx_nxt   = in_hash_value[IDX_W-1:0];
            state_nxt = S_READ;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        rem_nxt  = mod_rem;
        hash_nxt = hash_r << MOD_STEP;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == LAST_MOD) begin
          idx_nxt   = mod_rem;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (hit) begin
          state_nxt = S_OUT;
          if (req_r == REQ_INSERT) begin
            ram_we         = 1'b1;
            ram_wdata      = {1'b1, key_r, val_r};
            res_status_nxt = ST_OK;
            res_value_nxt  = '0;
          end else if (rd_valid) begin
            res_status_nxt = ST_OK;
            res_value_nxt  = 32'(rd_value);
            if (req_r == REQ_REMOVE) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b0, rd_key, rd_value};
            end
          end else begin
            res_status_nxt = ST_NOT_FOUND;
            res_value_nxt  = '0;
          end
        end else if (cnt_r == LAST_SLOT) begin
          res_status_nxt = ST_TABLE_FULL;
          res_value_nxt  = '0;
          state_nxt      = S_OUT;
        end else begin
          // read the next slot while this one is checked
          idx_nxt   = idx_inc;
          cnt_nxt   = cnt_r + 1'b1;
          ram_raddr = idx_inc;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    hash_r       <= hash_nxt;
    rem_r        <= rem_nxt;
    mcnt_r       <= mcnt_nxt;
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_value_out = out_value_r;

  `LPHT_ASSERT_RST(a_reset_clears,
    (!rst_n) |=> (state_r == S_CLEAR && !out_valid_r),
    "reset did not start the clearing pass")
  `LPHT_ASSERT(a_ram_write_src,
    ram_we |-> (state_r == S_CLEAR || state_r == S_CHECK),
    "slot write outside clear or check")
  `LPHT_ASSERT(a_insert_ok,
    (state_r == S_CHECK && hit && req_r == REQ_INSERT) |=> (res_status_r == ST_OK),
    "insert at a stop slot did not report ok")
  `LPHT_ASSERT(a_full_after_all,
    (state_r == S_OUT && res_status_r == ST_TABLE_FULL) |-> (cnt_r == LAST_SLOT),
    "table_full before probing every slot")
  `LPHT_ASSERT(a_out_load,
    $rose(out_valid_r) |-> $past(state_r == S_OUT),
    "result register loaded outside the output state")

endmodule

// ===== bench/linear_probe_hash_table_tb.sv =====
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int SINK_FREE  = 0;
  localparam int SINK_LIGHT = 1;
  localparam int SINK_HEAVY = 2;

  localparam int RANDOM_ITEMS = 800;
  localparam int POOL_SIZE    = 32;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } table_answer_t;

  // shadow copy of the slot array plus the answers still owed by the block
  class hash_table_tracker;
    bit            used   [SLOT_COUNT];
    logic [31:0]   key_of [SLOT_COUNT];
    logic [31:0]   val_of [SLOT_COUNT];
    table_answer_t answers_due [$];
    int            errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      errors = 0;
    endfunction

    function void note_request(logic [1:0] req, logic [31:0] key, logic [31:0] hash,
                               logic [31:0] value);
      int unsigned   idx;
      int unsigned   hit;
      bit            stopped;
      table_answer_t due;
      due.status = ST_NOT_FOUND;
      due.value  = '0;
      stopped    = 1'b0;
      hit        = 0;
      idx        = hash % SLOT_COUNT;
      if (req != REQ_UNUSED) begin
        for (int n = 0; n < SLOT_COUNT && !stopped; n++) begin
          if (!used[idx] || key_of[idx] == key) begin
            stopped = 1'b1;
            hit     = idx;
          end else begin
            idx = (idx + 1) % SLOT_COUNT;
          end
        end
        if (!stopped) begin
          due.status = ST_TABLE_FULL;
        end else if (req == REQ_INSERT) begin
          used[hit]   = 1'b1;
          key_of[hit] = key;
          val_of[hit] = value;
          due.status  = ST_OK;
        end else if (used[hit]) begin
          due.value  = val_of[hit];
          due.status = ST_OK;
          if (req == REQ_REMOVE) used[hit] = 1'b0;
        end
      end
      answers_due.push_back(due);
    endfunction

    function void check_result(logic [1:0] status, logic [31:0] value);
      table_answer_t due;
      if (answers_due.size() == 0) begin
        $error("unexpected item: out_status %0d, out_value_out 0x%08h", status, value);
        errors++;
        return;
      end
      due = answers_due.pop_front();
      if (status !== due.status) begin
        $error("out_status: expected %0d, actual %0d", due.status, status);
        errors++;
      end
      if (value !== due.value) begin
        $error("out_value_out: expected 0x%08h, actual 0x%08h", due.value, value);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_FIND;
  logic [31:0] in_key = '0;
  logic [31:0] in_hash_value = '0;
  logic [31:0] in_value_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_value_out;

  hash_table_tracker tracker = new();

  int burst_left = 0;
  bit steady = 1'b0;
  int sink_mode = SINK_FREE;
  int sink_left = 0;

  linear_probe_hash_table u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_key        (in_key),
    .in_hash_value (in_hash_value),
    .in_value_in   (in_value_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_value_out (out_value_out)
  );

  always #5 clk = ~clk;

  // sender works in bursts; valid only drops between bursts
  task automatic send_request(input logic [1:0] req, input logic [31:0] key,
                              input logic [31:0] hash, input logic [31:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_key        <= key;
    in_hash_value <= hash;
    in_value_in   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(req, key, hash, value);
  endtask

  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(SINK_FREE, SINK_HEAVY);
      sink_left = $urandom_range(10, 150);
    end else begin
      sink_left--;
    end
    case (sink_mode)
      SINK_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      SINK_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default:    out_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(out_status, out_value_out);
  end

  initial begin
    logic [31:0] pool_key  [POOL_SIZE];
    logic [31:0] pool_hash [POOL_SIZE];
    logic [1:0]  req;
    logic [31:0] key;
    logic [31:0] hash;
    int          counted;
    int          pick;
    int          slot;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, collisions, overwrite, wrap past the last slot,
    // a removed slot cutting a probe chain short, unused request type
    send_request(REQ_FIND,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h0000_0000, 32'hFFFF_FC00, 32'hFFFF_FFFF);
    send_request(REQ_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0000_0400, 32'h0000_0000);
    send_request(REQ_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_FIND,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000, 32'h1234_5678);
    send_request(REQ_FIND,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(REQ_INSERT, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
    send_request(REQ_INSERT, 32'h0BAD_F00D, 32'h8000_03FF, 32'h5A5A_5A5A);
    send_request(REQ_FIND,   32'h0BAD_F00D, 32'h0000_03FF, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_FIND,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_FIND,   32'h0BAD_F00D, 32'h0000_03FF, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000);
    send_request(REQ_UNUSED, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_FIND,   32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(REQ_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000);
    send_request(REQ_FIND,   32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000);
    send_request(REQ_REMOVE, 32'h0BAD_F00D, 32'h0000_0002, 32'h0000_0000);

    // fill every empty slot with a one-slot probe, so the table gets full
    steady = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!tracker.used[i]) begin
        hash = ($urandom & 32'hFFFF_FC00) | i;
        send_request(REQ_INSERT, 32'h7000_0000 | i, hash, $urandom);
      end
    end
    steady = 1'b0;
    // absent keys on a full table walk the whole ring
    send_request(REQ_INSERT, {16'h6000, 16'($urandom)}, $urandom, $urandom);
    send_request(REQ_REMOVE, {16'h6000, 16'($urandom)}, $urandom, $urandom);
    send_request(REQ_FIND,   {16'h6000, 16'($urandom)}, $urandom, $urandom);
    send_request(REQ_UNUSED, {16'h6000, 16'($urandom)}, $urandom, $urandom);
    slot = $urandom_range(0, SLOT_COUNT - 1);
    hash = ($urandom & 32'hFFFF_FC00) | slot;
    send_request(REQ_INSERT, tracker.key_of[slot], hash, $urandom);
    send_request(REQ_FIND,   tracker.key_of[slot], hash, $urandom);
    send_request(REQ_REMOVE, tracker.key_of[slot], hash, $urandom);
    send_request(REQ_FIND,   {16'h6000, 16'($urandom)}, hash, $urandom);
    // empty it again, each key straight from its own slot
    steady = 1'b1;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (tracker.used[i]) begin
        hash = ($urandom & 32'hFFFF_FC00) | i;
        send_request(REQ_REMOVE, tracker.key_of[i], hash, $urandom);
      end
    end

    // random traffic over a small key pool, most of whose hashes pile into a few
    // clusters, one of them straddling the wrap from the last slot to slot 0
    for (int j = 0; j < POOL_SIZE; j++) begin
      pool_key[j] = $urandom;
      case (j % 4)
        0:       slot = SLOT_COUNT - 3 + (j % 3);
        1:       slot = j % 3;
        2:       slot = 400 + (j % 2);
        default: slot = $urandom_range(0, SLOT_COUNT - 1);
      endcase
      pool_hash[j] = ($urandom & 32'hFFFF_FC00) | slot;
    end
    pool_key[0] = 32'h0000_0000;
    pool_key[1] = 32'hFFFF_FFFF;

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 40)      req = REQ_INSERT;
      else if (pick < 70) req = REQ_FIND;
      else if (pick < 95) req = REQ_REMOVE;
      else                req = REQ_UNUSED;
      pick = $urandom_range(0, POOL_SIZE - 1);
      key  = pool_key[pick];
      hash = pool_hash[pick];
      // noise: a stray key, or a pool key under a hash that disagrees with it
      if ($urandom_range(0, 99) < 6) begin
        key  = $urandom;
        hash = $urandom;
      end else if ($urandom_range(0, 99) < 8) begin
        hash = $urandom;
      end
      send_request(req, key, hash, $urandom);
      if (req != REQ_UNUSED) counted++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.answers_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("linear_probe_hash_table regression: pass");
    end else begin
      $display("linear_probe_hash_table regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("linear_probe_hash_table regression: fail");
    $finish;
  end

endmodule
